[rtl/mdars_pkg.sv]
// Shared types, constants and helpers for the row-major array store.
package mdars_pkg;

    localparam int NUM_DIMS  = 6;
    localparam int MAX_DIMS  = 6;
    localparam int DIM_LIMIT = (MAX_DIMS < NUM_DIMS) ? MAX_DIMS : NUM_DIMS;

    localparam int IDX_W     = 12;
    localparam int BOUND_W   = 13;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int STATUS_W  = 2;
    localparam int DIM_SEL_W = 3;

    localparam int S_TDATA_W = NUM_DIMS * IDX_W + VAL_W;
    localparam int M_TDATA_W = VAL_W;

    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic [BOUND_W-1:0]      t_bound;
    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [STATUS_W-1:0]     t_status;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [CFG_IDX_W-1:0]    t_cfg_idx;
    typedef logic [DIM_SEL_W-1:0]    t_dim_sel;

    localparam t_cfg_idx REG_DIM_COUNT   = 3'd0;
    localparam t_cfg_idx REG_DIM_BOUND_0 = 3'd1;
    localparam t_cfg_idx REG_DIM_BOUND_5 = 3'd6;

    localparam t_status ST_OK  = 2'd0;
    localparam t_status ST_OOB = 2'd1;
    localparam t_status ST_CAP = 2'd2;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef struct packed {
        logic     busy;
        t_dim_sel dims;
    } t_geom_status;

    function automatic t_dim_sel dims_in_use(input t_cnt cnt);
        t_dim_sel n;
        n = t_dim_sel'(cnt);
        if (cnt == '0) begin
            n = t_dim_sel'(1);
        end else if (int'(cnt) > DIM_LIMIT) begin
            n = t_dim_sel'(DIM_LIMIT);
        end
        return n;
    endfunction

endpackage

[rtl/mdars_ram.sv]
// Generic single-port synchronous RAM with registered read.
module mdars_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/mdars_stride.sv]
// Configuration registers and sequential row-major stride rebuild.
module mdars_stride import mdars_pkg::*; #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  t_cfg_idx                               i_cfg_idx,
    input  logic [BOUND_W-1:0]                     i_cfg_data,
    output t_bound                                 o_bound  [NUM_DIMS],
    output logic [$clog2(STORE_DEPTH+1)-1:0]       o_stride [NUM_DIMS],
    output t_geom_status                           o_geom
);

    localparam int SW = $clog2(STORE_DEPTH + 1);
    localparam int PW = SW + BOUND_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INIT = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0]    r_state;
    t_dim_sel      r_step;
    t_cnt          r_dim_count;
    t_bound        r_bound  [NUM_DIMS];
    logic [SW-1:0] r_stride [NUM_DIMS];

    t_dim_sel      dims;
    t_dim_sel      step_m1;
    t_dim_sel      cfg_sel;
    logic [PW-1:0] prod;
    logic [SW-1:0] prod_sat;

    assign dims    = dims_in_use(r_dim_count);
    assign step_m1 = r_step - t_dim_sel'(1);
    assign cfg_sel = t_dim_sel'(i_cfg_idx - REG_DIM_BOUND_0);
    assign prod    = PW'(r_bound[r_step]) * PW'(r_stride[r_step]);
    assign prod_sat = (prod > PW'(STORE_DEPTH)) ? SW'(STORE_DEPTH) : prod[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_dim_count <= t_cnt'(1);
            for (int d = 0; d < NUM_DIMS; d++) begin
                r_bound[d]  <= t_bound'(1);
                r_stride[d] <= (d == 0) ? SW'(1) : '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_DIM_COUNT) begin
                r_dim_count <= i_cfg_data[CNT_W-1:0];
                r_state     <= ST_INIT;
            end else if (i_cfg_idx <= REG_DIM_BOUND_5) begin
                r_bound[cfg_sel] <= i_cfg_data;
                r_state          <= ST_INIT;
            end
        end else begin
            unique case (r_state)
                ST_INIT: begin
                    for (int d = 0; d < NUM_DIMS; d++) begin
                        r_stride[d] <= (d == int'(dims) - 1) ? SW'(1) : '0;
                    end
                    r_step  <= dims - t_dim_sel'(1);
                    r_state <= (dims == t_dim_sel'(1)) ? ST_IDLE : ST_RUN;
                end
                ST_RUN: begin
                    r_stride[step_m1] <= prod_sat;
                    r_step            <= step_m1;
                    if (r_step == t_dim_sel'(1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_bound     = r_bound;
    assign o_stride    = r_stride;
    assign o_geom.busy = (r_state != ST_IDLE);
    assign o_geom.dims = dims;

endmodule

[rtl/multidim_array_row_major_store_top.sv]
// Row-major N-dimensional array store: index check, offset and element access.
// An accepted item passes through the s1, s2 and output registers before its result is valid.
// Throughput: one item per cycle while the result side takes items.
// A count or bound write holds off items while the strides
// are rebuilt, one multiply per cycle from the last dimension in use back.
// Reset (synchronous, active low) clears the pipeline and sets one dimension
// with all bounds 1; element contents are undefined until written.
module multidim_array_row_major_store_top import mdars_pkg::*; #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  t_cfg_idx               i_cfg_idx,
    input  logic [BOUND_W-1:0]     i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // idx_0, idx_1, idx_2, idx_3, idx_4, idx_5, write_value
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    // action
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // read_value
    output logic [M_TDATA_W-1:0]   m_axis_tdata,
    // status
    output logic [STATUS_W-1:0]    m_axis_tuser
);

    localparam int AW   = $clog2(STORE_DEPTH);
    localparam int SW   = $clog2(STORE_DEPTH + 1);
    localparam int MW   = SW + IDX_W;
    localparam int SUMW = SW + 3;

    t_bound        bound  [NUM_DIMS];
    logic [SW-1:0] stride [NUM_DIMS];
    t_geom_status  geom;

    logic          adv;
    logic          accept;
    logic          in_oob;
    logic [SW-1:0] in_prod [NUM_DIMS];
    logic [MW-1:0] in_mul  [NUM_DIMS];

    logic          r_s1_valid;
    logic          r_s1_oob;
    logic          r_s1_write;
    t_val          r_s1_wval;
    logic [SW-1:0] r_s1_prod [NUM_DIMS];

    logic [SUMW-1:0] sum;
    t_status         s1_status;
    logic            ram_en;
    logic            ram_we;
    logic [VAL_W-1:0] ram_rdata;

    logic          r_s2_valid;
    t_status       r_s2_status;
    logic          r_s2_read;

    logic            r_out_valid;
    t_status         r_out_status;
    logic [VAL_W-1:0] r_out_data;

    mdars_stride #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_stride (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_bound    (bound),
        .o_stride   (stride),
        .o_geom     (geom)
    );

    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = adv && !geom.busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_oob = 1'b0;
        for (int d = 0; d < NUM_DIMS; d++) begin
            in_mul[d] = MW'(stride[d]) * MW'(s_axis_tdata[d*IDX_W +: IDX_W]);
            in_prod[d] = (in_mul[d] >= MW'(STORE_DEPTH)) ? SW'(STORE_DEPTH)
                                                          : in_mul[d][SW-1:0];
            if ((d < int'(geom.dims)) &&
                (BOUND_W'(s_axis_tdata[d*IDX_W +: IDX_W]) >= bound[d])) begin
                in_oob = 1'b1;
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int d = 0; d < NUM_DIMS; d++) begin
            sum = sum + SUMW'(r_s1_prod[d]);
        end
    end

    always_comb begin
        priority if (r_s1_oob) begin
            s1_status = ST_OOB;
        end else if (sum >= SUMW'(STORE_DEPTH)) begin
            s1_status = ST_CAP;
        end else begin
            s1_status = ST_OK;
        end
    end

    assign ram_en = adv && r_s1_valid;
    assign ram_we = ram_en && (s1_status == ST_OK) && (r_s1_write == ACT_WRITE);

    mdars_ram #(
        .WIDTH (VAL_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (sum[AW-1:0]),
        .i_wdata (r_s1_wval),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= accept;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (accept) begin
                r_s1_oob   <= in_oob;
                r_s1_write <= s_axis_tuser;
                r_s1_wval  <= t_val'(s_axis_tdata[NUM_DIMS*IDX_W +: VAL_W]);
                r_s1_prod  <= in_prod;
            end
            r_s2_status  <= s1_status;
            r_s2_read    <= (s1_status == ST_OK) && (r_s1_write == ACT_READ);
            r_out_status <= r_s2_status;
            r_out_data   <= r_s2_read ? ram_rdata : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

endmodule

[rtl/mdars_chk.sv]
// Port-level checks for the row-major array store, bound to the top level.
module mdars_chk import mdars_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input t_cfg_idx             i_cfg_idx,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [STATUS_W-1:0]  m_axis_tuser
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
        else $error("nonzero read value with failing status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_OOB) ||
                          (m_axis_tuser == ST_CAP))
        else $error("undefined status code");

    a_cfg_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_idx <= REG_DIM_BOUND_5) |=> !s_axis_tready)
        else $error("item taken while strides rebuild");

endmodule

bind multidim_array_row_major_store_top mdars_chk u_mdars_chk (.*);

[tb/mdars_tb_pkg.sv]
// Item types and the shadow scoreboard for the row-major array store testbench.
package mdars_tb_pkg;
    import mdars_pkg::*;

    localparam int unsigned STORE_CELLS = 4096;

    typedef logic [NUM_DIMS-1:0][IDX_W-1:0] t_spot;

    typedef struct packed {
        logic  action;
        t_spot spot;
        t_val  wval;
    } t_cell_access;

    typedef struct packed {
        t_status status;
        t_val    read_value;
    } t_reply;

    class store_shadow;
        int unsigned     dims;
        int unsigned     bounds[NUM_DIMS];
        longint unsigned strides[NUM_DIMS];
        t_val            cells[STORE_CELLS];
        bit              written[STORE_CELLS];
        t_reply          replies_due[$];
        int unsigned     errors;
        int unsigned     checked;
        int unsigned     reads_done;
        int unsigned     writes_done;
        int unsigned     oob_seen;
        int unsigned     cap_seen;

        function new();
            dims = 1;
            foreach (bounds[d]) begin
                bounds[d] = 1;
            end
            rebuild_strides();
        endfunction

        function void rebuild_strides();
            longint unsigned s;
            foreach (strides[d]) begin
                strides[d] = 0;
            end
            strides[dims-1] = 1;
            for (int d = dims - 1; d > 0; d--) begin
                s = bounds[d] * strides[d];
                strides[d-1] = (s > STORE_CELLS) ? STORE_CELLS : s;
            end
        endfunction

        function void write_reg(input t_cfg_idx idx, input t_bound value);
            if (idx == REG_DIM_COUNT) begin
                if (value[CNT_W-1:0] == '0) begin
                    dims = 1;
                end else if (value[CNT_W-1:0] > DIM_LIMIT) begin
                    dims = DIM_LIMIT;
                end else begin
                    dims = value[CNT_W-1:0];
                end
            end else if (idx <= REG_DIM_BOUND_5) begin
                bounds[idx - REG_DIM_BOUND_0] = value;
            end else begin
                return;
            end
            rebuild_strides();
        endfunction

        function t_status access_result(input t_cell_access a, output int unsigned offset);
            longint unsigned sum;
            sum = 0;
            offset = 0;
            for (int d = 0; d < dims; d++) begin
                if (a.spot[d] >= bounds[d]) begin
                    return ST_OOB;
                end
                sum += strides[d] * a.spot[d];
            end
            if (sum >= STORE_CELLS) begin
                return ST_CAP;
            end
            offset = sum;
            return ST_OK;
        endfunction

        function bit read_is_defined(input t_cell_access a);
            int unsigned offset;
            if (access_result(a, offset) != ST_OK) begin
                return 1'b1;
            end
            return written[offset];
        endfunction

        function void note_access(input t_cell_access a);
            t_reply      r;
            int unsigned offset;
            r.status     = access_result(a, offset);
            r.read_value = '0;
            if (r.status == ST_OK) begin
                if (a.action == ACT_WRITE) begin
                    cells[offset]   = a.wval;
                    written[offset] = 1'b1;
                    writes_done++;
                end else begin
                    r.read_value = cells[offset];
                    reads_done++;
                end
            end else if (r.status == ST_OOB) begin
                oob_seen++;
            end else begin
                cap_seen++;
            end
            replies_due.push_back(r);
        endfunction

        function void check_reply(input t_status status, input t_val read_value);
            t_reply want;
            if (replies_due.size() == 0) begin
                $error("result with nothing outstanding: status %0d read_value %0d",
                       status, read_value);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            checked++;
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                errors++;
            end
            if (read_value !== want.read_value) begin
                $error("read_value: expected %0d, actual %0d", want.read_value, read_value);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return replies_due.size();
        endfunction
    endclass

endpackage

[tb/multidim_array_row_major_store_top_test.sv]
// Top-level testbench for the row-major array store: directed and random accesses.
module multidim_array_row_major_store_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mdars_pkg::*;
    import mdars_tb_pkg::*;

    localparam int unsigned PHASES       = 10;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned PRESSURE_AT  = 1200;
    localparam int unsigned RECENT_DEPTH = 32;
    localparam int unsigned SWAP_AT      = 520;
    localparam int unsigned CALM_AT      = 1040;
    localparam t_cfg_idx    REG_UNUSED   = REG_DIM_BOUND_5 + 3'd1;

    // dim_count, dim_bound_0 .. dim_bound_5; row 0 is the reset shape
    int unsigned geom_table [PHASES][1+NUM_DIMS] = '{
        '{1, 1, 1, 1, 1, 1, 1},
        '{0, 4096, 1, 1, 1, 1, 1},
        '{7, 4, 4, 4, 4, 4, 4},
        '{2, 8191, 4096, 1, 1, 1, 1},
        '{3, 7, 0, 9, 1, 1, 1},
        '{3, 20, 15, 16, 1, 1, 1},
        '{6, 4096, 4096, 4096, 4096, 4096, 4096},
        '{4, 8, 1, 16, 32, 1, 1},
        '{5, 3, 5, 2, 7, 11, 1},
        '{1, 4096, 4096, 4096, 4096, 4096, 4096}
    };
    int unsigned phase_items [PHASES] = '{30, 150, 250, 120, 60, 200, 120, 250, 200, 150};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    t_cfg_idx             i_cfg_idx;
    logic [BOUND_W-1:0]   i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]  m_axis_tuser;

    store_shadow shadow;
    t_spot       recent_spots[$];
    int unsigned items_sent;
    int unsigned send_idle_pct = 37;
    int unsigned recv_idle_pct = 78;
    int unsigned hold_requests;
    int unsigned holds_served;
    int unsigned cycle_count;

    multidim_array_row_major_store_top #(.STORE_DEPTH(STORE_CELLS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, shadow.pending());
        $display("== FAIL ==");
        $finish;
    end

    // result side: random stalls, plus a long hold-off when requested
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            shadow.check_reply(m_axis_tuser, t_val'(m_axis_tdata));
        end
    end

    function automatic t_spot spot_of(input int unsigned i0, input int unsigned i1,
                                      input int unsigned i2, input int unsigned i3,
                                      input int unsigned i4, input int unsigned i5);
        return {t_idx'(i5), t_idx'(i4), t_idx'(i3), t_idx'(i2), t_idx'(i1), t_idx'(i0)};
    endfunction

    function automatic t_spot random_spot(input bit noise);
        t_spot       s;
        int unsigned b;
        int unsigned span;
        int unsigned pick;
        s = '0;
        for (int d = 0; d < NUM_DIMS; d++) begin
            b    = shadow.bounds[d];
            span = (b > STORE_CELLS) ? STORE_CELLS : b;
            pick = $urandom_range(99);
            if (noise || d >= shadow.dims || b == 0 || pick < 3) begin
                s[d] = t_idx'($urandom);
            end else if (pick < 7) begin
                case ($urandom_range(3))
                    0:       s[d] = '0;
                    1:       s[d] = t_idx'(span - 1);
                    2:       s[d] = t_idx'((b > STORE_CELLS - 1) ? STORE_CELLS - 1 : b);
                    default: s[d] = '1;
                endcase
            end else begin
                s[d] = t_idx'($urandom_range(span - 1, 0));
            end
        end
        return s;
    endfunction

    task automatic send_access(input t_cell_access a);
        if (items_sent == SWAP_AT) begin
            send_idle_pct = 78;
            recv_idle_pct = 37;
        end else if (items_sent == CALM_AT) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if (items_sent == PRESSURE_AT) begin
            hold_requests++;
        end
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {a.wval, a.spot};
        s_axis_tuser  = a.action;
        do @(posedge i_clk); while (!s_axis_tready);
        shadow.note_access(a);
        items_sent++;
        if (a.action == ACT_WRITE) begin
            recent_spots.push_back(a.spot);
            if (recent_spots.size() > RECENT_DEPTH) begin
                void'(recent_spots.pop_front());
            end
        end
    endtask

    task automatic send_fixed(input logic action, input t_spot spot, input t_val value);
        t_cell_access a;
        a.action = action;
        a.spot   = spot;
        a.wval   = value;
        send_access(a);
    endtask

    task automatic send_random_access();
        t_cell_access a;
        a.action = $urandom_range(1) ? ACT_WRITE : ACT_READ;
        a.wval   = t_val'($urandom);
        if (a.action == ACT_READ && recent_spots.size() > 0 && $urandom_range(1)) begin
            a.spot = recent_spots[$urandom_range(recent_spots.size() - 1)];
        end else begin
            a.spot = random_spot($urandom_range(99) < 8);
        end
        // never read a cell that has not been written
        if (a.action == ACT_READ && !shadow.read_is_defined(a)) begin
            a.action = ACT_WRITE;
        end
        send_access(a);
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (shadow.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_setting(input t_cfg_idx idx, input t_bound value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        shadow.write_reg(idx, value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_geometry(input int unsigned p);
        settle();
        write_setting(REG_DIM_COUNT, t_bound'(geom_table[p][0]));
        for (int d = 0; d < NUM_DIMS; d++) begin
            write_setting(t_cfg_idx'(REG_DIM_BOUND_0 + d), t_bound'(geom_table[p][1+d]));
        end
    endtask

    initial begin
        shadow        = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_DIM_COUNT;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_READ;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int unsigned p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                program_geometry(p);
            end
            if (p == 5) begin
                write_setting(REG_UNUSED, t_bound'($urandom));
            end
            case (p)
                0: begin
                    send_fixed(ACT_WRITE, spot_of(0, 4095, 4095, 4095, 4095, 4095),
                               t_val'(32'h7FFF_FFFF));
                    send_fixed(ACT_READ, spot_of(0, 4095, 4095, 4095, 4095, 4095), '0);
                    send_fixed(ACT_READ, spot_of(1, 0, 0, 0, 0, 0), '0);
                    send_fixed(ACT_WRITE, spot_of(4095, 0, 0, 0, 0, 0), '1);
                    send_fixed(ACT_WRITE, spot_of(0, 0, 0, 0, 0, 0), t_val'(32'h8000_0000));
                    send_fixed(ACT_READ, spot_of(0, 0, 0, 0, 0, 0), '0);
                end
                1: begin
                    send_fixed(ACT_WRITE, spot_of(4095, 1, 2, 3, 4, 5), '1);
                    send_fixed(ACT_READ, spot_of(4095, 0, 0, 0, 0, 0), '0);
                end
                2: begin
                    send_fixed(ACT_WRITE, spot_of(3, 3, 3, 3, 3, 3), t_val'(32'h5A5A_A5A5));
                    send_fixed(ACT_READ, spot_of(3, 3, 3, 3, 3, 3), '0);
                    send_fixed(ACT_READ, spot_of(0, 0, 0, 0, 0, 4), '0);
                    send_fixed(ACT_READ, spot_of(0, 0, 0, 0, 0, 0), '0);
                end
                3: begin
                    send_fixed(ACT_READ, spot_of(0, 4095, 0, 0, 0, 0), '0);
                    send_fixed(ACT_WRITE, spot_of(1, 0, 0, 0, 0, 0), t_val'(32'h1234_5678));
                    send_fixed(ACT_READ, spot_of(4095, 4095, 0, 0, 0, 0), '0);
                end
                4: begin
                    send_fixed(ACT_READ, spot_of(0, 0, 0, 0, 0, 0), '0);
                end
                6: begin
                    send_fixed(ACT_WRITE, spot_of(0, 0, 0, 0, 0, 4095), t_val'(32'hC0DE_0001));
                    send_fixed(ACT_READ, spot_of(0, 0, 0, 0, 1, 0), '0);
                    send_fixed(ACT_READ, spot_of(0, 0, 0, 0, 0, 4095), '0);
                end
                default: begin
                end
            endcase
            repeat (phase_items[p]) send_random_access();
        end
        settle();

        $display("ran %0d items across %0d array shapes, from one to six dimensions,",
                 items_sent, PHASES);
        $display("with %0d results checked: %0d reads, %0d writes, %0d out of bounds, %0d past capacity",
                 shadow.checked, shadow.reads_done, shadow.writes_done,
                 shadow.oob_seen, shadow.cap_seen);
        if (shadow.errors == 0 && shadow.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/mdars_pkg.sv
rtl/mdars_ram.sv
rtl/mdars_stride.sv
rtl/multidim_array_row_major_store_top.sv
rtl/mdars_chk.sv
tb/mdars_tb_pkg.sv
tb/multidim_array_row_major_store_top_test.sv
